[rtl/core/wbsp_pkg.sv]
// Package for the background-scan policy: payload types, codes, constants and time helpers.
package wbsp_pkg;

  localparam logic [11:0] DEFAULT_PEAK_START       = 12'd800;
  localparam logic [11:0] DEFAULT_PEAK_END         = 12'd1700;
  localparam logic [11:0] DEFAULT_PEAK_INTERVAL    = 12'd600;
  localparam logic [11:0] DEFAULT_OFFPEAK_INTERVAL = 12'd0;
  localparam logic [11:0] MAX_AUTO_INTERVAL        = 12'd1800;
  localparam logic [11:0] LAST_HHMM                = 12'd2359;
  localparam logic [6:0]  HHMM_HOURS               = 7'd100;
  localparam logic [17:0] DAY_SECONDS              = 18'd86400;

  // floor(v / 100) as (v * 5243) >> 19, exact for v up to 2399
  localparam logic [12:0] HOURS_RECIP = 13'd5243;
  localparam int          HOURS_SHIFT = 19;

  localparam logic [2:0] CFG_PEAK_START    = 3'd0;
  localparam logic [2:0] CFG_PEAK_END      = 3'd1;
  localparam logic [2:0] CFG_PEAK_INTERVAL = 3'd2;
  localparam logic [2:0] CFG_OFFPEAK_IVAL  = 3'd3;
  localparam logic [2:0] CFG_AGENT_PRESENT = 3'd4;

  typedef enum logic [2:0] {
    OP_SETTING   = 3'd0,
    OP_SCAN_DONE = 3'd1,
    OP_NOT_CONN  = 3'd2,
    OP_TIMER     = 3'd3,
    OP_AGENT_IVL = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    AGENT_NONE  = 2'd0,
    AGENT_START = 2'd1,
    AGENT_STOP  = 2'd2
  } agent_cmd_t;

  typedef enum logic [1:0] {
    TIMER_NONE = 2'd0,
    TIMER_STOP = 2'd1,
    TIMER_ARM  = 2'd2
  } timer_act_t;

  localparam logic [1:0] MODE_CODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_CODE_FIXED = 2'd1;
  localparam logic [1:0] MODE_CODE_AUTO  = 2'd2;
  localparam logic [1:0] MODE_CODE_AGENT = 2'd3;

  typedef enum logic [3:0] {
    MODE_OFF   = 4'b0001,
    MODE_FIXED = 4'b0010,
    MODE_AUTO  = 4'b0100,
    MODE_AGENT = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic        setting_automatic;
    logic [15:0] interval_value;
    logic [16:0] now_seconds;
  } in_t;

  typedef struct packed {
    logic        cancel_scan;
    logic        scan_request;
    logic [15:0] scan_expiry;
    logic [1:0]  agent_command;
    logic [1:0]  timer_action;
    logic [10:0] change_at_minute;
    logic        change_next_day;
    logic [15:0] interval_now;
    logic        scan_enabled;
    logic [1:0]  mode_now;
  } out_t;

  typedef struct packed {
    logic [11:0] peak_start_hhmm;
    logic [11:0] peak_end_hhmm;
    logic [11:0] peak_interval;
    logic [11:0] offpeak_interval;
    logic        agent_present;
  } cfg_t;

  // peak window view of one event time
  typedef struct packed {
    logic        in_peak;
    timer_act_t  timer_action;
    logic [10:0] change_min;
    logic        change_next;
    logic [15:0] auto_ival;
  } win_t;

  function automatic logic [10:0] hhmm_to_min(input logic [11:0] v);
    logic [24:0] prod;
    logic [4:0]  hrs;
    logic [11:0] mins;
    logic [10:0] mclip;
    prod  = 25'(v) * 25'(HOURS_RECIP);
    hrs   = prod[HOURS_SHIFT+4:HOURS_SHIFT];
    mins  = v - 12'(hrs) * 12'(HHMM_HOURS);
    mclip = (mins > 12'd59) ? 11'd59 : 11'(mins);
    return 11'(hrs) * 11'd60 + mclip;
  endfunction

  function automatic logic [17:0] min_to_sec(input logic [10:0] m);
    return (18'(m) << 6) - (18'(m) << 2);
  endfunction

  function automatic logic [1:0] mode_code(input mode_t m);
    logic [1:0] c;
    case (m)
      MODE_FIXED: c = MODE_CODE_FIXED;
      MODE_AUTO:  c = MODE_CODE_AUTO;
      MODE_AGENT: c = MODE_CODE_AGENT;
      default:    c = MODE_CODE_OFF;
    endcase
    return c;
  endfunction

endpackage

[rtl/core/wlan_background_scan_policy.sv]
// Top level of the background-scan policy: channel registers, config registers, policy state.
//
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------------
//  in_     | in_valid / in_stall    | in_data   (opcode, setting, interval, time)
//  out_    | out_valid / out_stall  | out_data  (commands, timer, interval, mode)
//  cfg_    | cfg_valid / cfg_ready  | cfg_index, cfg_data (12 bit)
//
// One event per cycle while the output is not stalled; a beat enters the input
// register and its result is registered in the output register, set by the
// single decision stage between those two registers.
// rst_n is synchronous: mode off, interval never, config registers zero.
// out_stall holds the output register; in_stall rises only when the input
// register holds a beat and the output register is full and stalled.
module wlan_background_scan_policy (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  wbsp_pkg::in_t     in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output wbsp_pkg::out_t    out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [11:0]       cfg_data
);
  import wbsp_pkg::*;

  cfg_t        cfg_r;
  in_t         in_r;
  logic        in_vld_r;
  out_t        out_r;
  logic        out_vld_r;
  mode_t       mode_r;
  mode_t       mode_nxt;
  logic [15:0] cur_ival_r;
  logic [15:0] cur_ival_nxt;
  win_t        win;
  out_t        res;
  logic        advance;

  assign cfg_ready = 1'b1;
  assign advance   = in_vld_r && !(out_vld_r && out_stall);
  assign in_stall  = in_vld_r && !advance;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  wbsp_window u_window (
    .cfg         (cfg_r),
    .now_seconds (in_r.now_seconds),
    .win         (win)
  );

  wbsp_decide u_decide (
    .evt           (in_r),
    .mode          (mode_r),
    .cur_ival      (cur_ival_r),
    .agent_present (cfg_r.agent_present),
    .win           (win),
    .mode_nxt      (mode_nxt),
    .cur_ival_nxt  (cur_ival_nxt),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PEAK_START:    cfg_r.peak_start_hhmm  <= cfg_data;
        CFG_PEAK_END:      cfg_r.peak_end_hhmm    <= cfg_data;
        CFG_PEAK_INTERVAL: cfg_r.peak_interval    <= cfg_data;
        CFG_OFFPEAK_IVAL:  cfg_r.offpeak_interval <= cfg_data;
        CFG_AGENT_PRESENT: cfg_r.agent_present    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      mode_r     <= MODE_OFF;
      cur_ival_r <= 16'd0;
    end else begin
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r  <= 1'b1;
        mode_r     <= mode_nxt;
        cur_ival_r <= cur_ival_nxt;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
    if (advance) begin
      out_r <= res;
    end
  end

  // result reports the state it leaves behind
  a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (out_r.interval_now == cur_ival_r) && (out_r.mode_now == mode_code(mode_r)))
    else $error("result interval or mode differs from stored state");

  a_enabled_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_r.scan_enabled == (out_r.interval_now != 16'd0)))
    else $error("scan_enabled inconsistent with interval");

  a_expiry_only_with_request: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_r.scan_request) |-> (out_r.scan_expiry == 16'd0))
    else $error("expiry set without a scan request");

  a_change_time_only_when_armed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.timer_action != TIMER_ARM) |->
      (out_r.change_at_minute == 11'd0 && !out_r.change_next_day))
    else $error("change time set without arming the timer");

  a_auto_mode_has_no_agent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.agent_command == AGENT_START) |-> (out_r.mode_now == MODE_CODE_AGENT))
    else $error("agent started outside agent mode");

endmodule

[rtl/core/wbsp_window.sv]
// Peak window evaluation: where the event time falls, next change time, automatic interval.
module wbsp_window (
  input  wbsp_pkg::cfg_t      cfg,
  input  logic [16:0]         now_seconds,
  output wbsp_pkg::win_t      win
);
  import wbsp_pkg::*;

  logic        use_dflt;
  logic [11:0] s_hhmm;
  logic [11:0] e_hhmm;
  logic        wraps;
  logic [10:0] s_min;
  logic [10:0] e_min;
  logic [17:0] s_sec;
  logic [17:0] e_sec;
  logic [17:0] now_ext;
  logic        before_win;
  logic        inside_win;
  logic [11:0] pk_ival;
  logic [11:0] off_ival;

  assign use_dflt = (cfg.peak_start_hhmm > LAST_HHMM) || (cfg.peak_end_hhmm > LAST_HHMM);
  assign s_hhmm   = use_dflt ? DEFAULT_PEAK_START : cfg.peak_start_hhmm;
  assign e_hhmm   = use_dflt ? DEFAULT_PEAK_END : cfg.peak_end_hhmm;
  assign wraps    = s_hhmm > e_hhmm;
  assign s_min    = hhmm_to_min(s_hhmm);
  assign e_min    = hhmm_to_min(e_hhmm);
  assign s_sec    = min_to_sec(s_min);
  assign e_sec    = min_to_sec(e_min) + (wraps ? DAY_SECONDS : 18'd0);
  assign now_ext  = 18'(now_seconds);

  assign before_win = now_ext < s_sec;
  assign inside_win = !before_win && (now_ext < e_sec);

  assign pk_ival  = (cfg.peak_interval > MAX_AUTO_INTERVAL) ? DEFAULT_PEAK_INTERVAL
                                                             : cfg.peak_interval;
  assign off_ival = (cfg.offpeak_interval > MAX_AUTO_INTERVAL) ? DEFAULT_OFFPEAK_INTERVAL
                                                                : cfg.offpeak_interval;

  always_comb begin
    win.in_peak     = inside_win;
    win.auto_ival   = 16'(inside_win ? pk_ival : off_ival);
    win.change_min  = 11'd0;
    win.change_next = 1'b0;
    if (s_hhmm == e_hhmm) begin
      win.timer_action = TIMER_STOP;
    end else begin
      win.timer_action = TIMER_ARM;
      if (before_win) begin
        win.change_min = s_min;
      end else if (inside_win) begin
        win.change_min  = e_min;
        win.change_next = wraps;
      end else begin
        win.change_min  = s_min;
        win.change_next = 1'b1;
      end
    end
  end

endmodule

[rtl/core/wbsp_decide.sv]
// Policy decision: next mode and interval plus the result beat for one event.
module wbsp_decide (
  input  wbsp_pkg::in_t       evt,
  input  wbsp_pkg::mode_t     mode,
  input  logic [15:0]         cur_ival,
  input  logic                agent_present,
  input  wbsp_pkg::win_t      win,
  output wbsp_pkg::mode_t     mode_nxt,
  output logic [15:0]         cur_ival_nxt,
  output wbsp_pkg::out_t      res
);
  import wbsp_pkg::*;

  logic        cancel;
  logic        req;
  logic [15:0] expiry;
  agent_cmd_t  agent;
  timer_act_t  timer;
  logic [10:0] chg_min;
  logic        chg_next;
  logic        run_fsm;
  logic        autom;
  logic [15:0] val;
  logic [15:0] newv;

  always_comb begin
    cancel       = 1'b0;
    req          = 1'b0;
    expiry       = 16'd0;
    agent        = AGENT_NONE;
    timer        = TIMER_NONE;
    chg_min      = 11'd0;
    chg_next     = 1'b0;
    mode_nxt     = mode;
    cur_ival_nxt = cur_ival;
    run_fsm      = 1'b0;
    autom        = evt.setting_automatic;
    val          = evt.interval_value;
    newv         = 16'd0;

    case (opcode_t'(evt.opcode))
      OP_SETTING: run_fsm = 1'b1;
      OP_SCAN_DONE: begin
        req    = cur_ival != 16'd0;
        expiry = cur_ival;
      end
      OP_NOT_CONN: req = cur_ival != 16'd0;
      OP_TIMER: begin
        run_fsm = mode == MODE_AUTO;
        autom   = 1'b1;
        val     = 16'd0;
      end
      OP_AGENT_IVL: begin
        if (mode == MODE_AGENT && val != cur_ival) begin
          cur_ival_nxt = val;
          if (cur_ival == 16'd0 || cur_ival > val) begin
            cancel = 1'b1;
            req    = val != 16'd0;
          end
        end
      end
      default: ;
    endcase

    if (run_fsm) begin
      case (mode)
        MODE_OFF, MODE_FIXED: begin
          if (autom) begin
            cancel       = mode == MODE_FIXED;
            cur_ival_nxt = 16'd0;
            if (agent_present) begin
              mode_nxt = MODE_AGENT;
              agent    = AGENT_START;
            end else begin
              timer        = win.timer_action;
              chg_min      = win.change_min;
              chg_next     = win.change_next;
              cur_ival_nxt = win.auto_ival;
              req          = win.auto_ival != 16'd0;
              mode_nxt     = MODE_AUTO;
            end
          end else if (val == 16'd0) begin
            cancel       = mode == MODE_FIXED;
            cur_ival_nxt = 16'd0;
            mode_nxt     = MODE_OFF;
          end else if (mode == MODE_OFF) begin
            cur_ival_nxt = val;
            req          = 1'b1;
            mode_nxt     = MODE_FIXED;
          end else if (val != cur_ival) begin
            cancel       = 1'b1;
            cur_ival_nxt = val;
            req          = 1'b1;
            expiry       = (cur_ival > val) ? 16'd0 : val;
          end
        end
        MODE_AUTO: begin
          if (autom) begin
            timer    = win.timer_action;
            chg_min  = win.change_min;
            chg_next = win.change_next;
            newv     = win.auto_ival;
            if (newv == 16'd0) begin
              cancel       = 1'b1;
              cur_ival_nxt = 16'd0;
            end else if (newv != cur_ival) begin
              cancel       = 1'b1;
              cur_ival_nxt = newv;
              req          = 1'b1;
              expiry       = (cur_ival > newv) ? 16'd0 : newv;
            end
          end else begin
            timer        = TIMER_STOP;
            cancel       = 1'b1;
            cur_ival_nxt = val;
            req          = val != 16'd0;
            mode_nxt     = (val == 16'd0) ? MODE_OFF : MODE_FIXED;
          end
        end
        MODE_AGENT: begin
          if (!autom) begin
            agent        = AGENT_STOP;
            cancel       = 1'b1;
            cur_ival_nxt = val;
            req          = val != 16'd0;
            mode_nxt     = (val == 16'd0) ? MODE_OFF : MODE_FIXED;
          end
        end
        default: ;
      endcase
    end

    res.cancel_scan      = cancel;
    res.scan_request     = req;
    res.scan_expiry      = req ? expiry : 16'd0;
    res.agent_command    = agent;
    res.timer_action     = timer;
    res.change_at_minute = chg_min;
    res.change_next_day  = chg_next;
    res.interval_now     = cur_ival_nxt;
    res.scan_enabled     = cur_ival_nxt != 16'd0;
    res.mode_now         = mode_code(mode_nxt);
  end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Testbench for the background-scan policy: predicts each event's decision and checks every output beat.
module tb;
  import wbsp_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_EVENTS = 172;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 4;

  localparam logic [2:0] OP_UNUSED_LO  = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI  = 3'd7;
  localparam logic [2:0] CFG_UNUSED_LO = 3'd5;

  typedef enum int {WIN_BEFORE, WIN_INSIDE, WIN_AFTER} win_pos_t;

  class decision_board;
    logic [11:0] peak_start, peak_end, peak_ival, offpeak_ival;
    logic        agent_on;
    logic [1:0]  mode;
    logic [15:0] ival;
    out_t        nxt;
    out_t        pending_decisions[$];
    int          errors;

    function new();
      peak_start   = '0;
      peak_end     = '0;
      peak_ival    = '0;
      offpeak_ival = '0;
      agent_on     = 1'b0;
      mode         = MODE_CODE_OFF;
      ival         = '0;
      errors       = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [11:0] v);
      case (idx)
        CFG_PEAK_START:    peak_start   = v;
        CFG_PEAK_END:      peak_end     = v;
        CFG_PEAK_INTERVAL: peak_ival    = v;
        CFG_OFFPEAK_IVAL:  offpeak_ival = v;
        CFG_AGENT_PRESENT: agent_on     = v[0];
        default: ;
      endcase
    endfunction

    function bit use_defaults();
      return (peak_start > LAST_HHMM) || (peak_end > LAST_HHMM);
    endfunction

    function int win_start();
      return use_defaults() ? int'(DEFAULT_PEAK_START) : int'(peak_start);
    endfunction

    function int win_end();
      return use_defaults() ? int'(DEFAULT_PEAK_END) : int'(peak_end);
    endfunction

    function int hhmm_minutes(int v);
      int m;
      m = v % int'(HHMM_HOURS);
      if (m > 59) m = 59;
      return (v / int'(HHMM_HOURS)) * 60 + m;
    endfunction

    function int start_sec();
      return hhmm_minutes(win_start()) * 60;
    endfunction

    function int end_sec();
      return hhmm_minutes(win_end()) * 60 +
             ((win_start() > win_end()) ? int'(DAY_SECONDS) : 0);
    endfunction

    function win_pos_t locate(int now);
      if (now < start_sec()) return WIN_BEFORE;
      if (now < end_sec()) return WIN_INSIDE;
      return WIN_AFTER;
    endfunction

    function logic [15:0] auto_interval(int now);
      if (locate(now) == WIN_INSIDE)
        return (peak_ival > MAX_AUTO_INTERVAL) ? 16'(DEFAULT_PEAK_INTERVAL) : 16'(peak_ival);
      return (offpeak_ival > MAX_AUTO_INTERVAL) ? 16'(DEFAULT_OFFPEAK_INTERVAL)
                                                : 16'(offpeak_ival);
    endfunction

    function void arm_change(int now);
      nxt.timer_action = TIMER_STOP;
      if (win_start() == win_end()) return;
      nxt.timer_action = TIMER_ARM;
      case (locate(now))
        WIN_BEFORE: begin
          nxt.change_at_minute = 11'(hhmm_minutes(win_start()));
          nxt.change_next_day  = 1'b0;
        end
        WIN_INSIDE: begin
          nxt.change_at_minute = 11'(hhmm_minutes(win_end()));
          nxt.change_next_day  = (win_start() > win_end());
        end
        default: begin
          nxt.change_at_minute = 11'(hhmm_minutes(win_start()));
          nxt.change_next_day  = 1'b1;
        end
      endcase
    endfunction

    function void scan_now();
      if (ival != 0) begin
        nxt.scan_request = 1'b1;
        nxt.scan_expiry  = '0;
      end
    endfunction

    function void scan_later();
      if (ival != 0) begin
        nxt.scan_request = 1'b1;
        nxt.scan_expiry  = ival;
      end
    endfunction

    function void enter_auto(int now);
      if (agent_on) begin
        mode = MODE_CODE_AGENT;
        nxt.agent_command = AGENT_START;
      end else begin
        arm_change(now);
        ival = auto_interval(now);
        scan_now();
        mode = MODE_CODE_AUTO;
      end
    endfunction

    function void retune(logic [15:0] v);
      logic [15:0] old;
      old = ival;
      if (v == old) return;
      nxt.cancel_scan = 1'b1;
      ival = v;
      if (old > v) scan_now();
      else scan_later();
    endfunction

    function void apply_setting(bit autom, logic [15:0] v, int now);
      logic [15:0] ai;
      case (mode)
        MODE_CODE_OFF: begin
          if (autom) enter_auto(now);
          else if (v != 0) begin
            ival = v;
            scan_now();
            mode = MODE_CODE_FIXED;
          end
        end
        MODE_CODE_FIXED: begin
          if (autom) begin
            ival = '0;
            nxt.cancel_scan = 1'b1;
            enter_auto(now);
          end else if (v == 0) begin
            ival = '0;
            nxt.cancel_scan = 1'b1;
            mode = MODE_CODE_OFF;
          end else retune(v);
        end
        MODE_CODE_AUTO: begin
          if (autom) begin
            arm_change(now);
            ai = auto_interval(now);
            if (ai == 0) begin
              nxt.cancel_scan = 1'b1;
              ival = '0;
            end else retune(ai);
          end else begin
            ival = v;
            nxt.timer_action = TIMER_STOP;
            nxt.cancel_scan = 1'b1;
            if (v == 0) mode = MODE_CODE_OFF;
            else begin
              scan_now();
              mode = MODE_CODE_FIXED;
            end
          end
        end
        default: begin
          if (!autom) begin
            nxt.agent_command = AGENT_STOP;
            nxt.cancel_scan = 1'b1;
            ival = v;
            if (v == 0) mode = MODE_CODE_OFF;
            else begin
              scan_now();
              mode = MODE_CODE_FIXED;
            end
          end
        end
      endcase
    endfunction

    function void agent_update(logic [15:0] v);
      if (mode != MODE_CODE_AGENT) return;
      if (ival == v) return;
      if (ival == 0 || ival > v) begin
        nxt.cancel_scan = 1'b1;
        ival = v;
        scan_now();
      end else ival = v;
    endfunction

    function void predict_event(in_t d);
      int now;
      now = int'(d.now_seconds);
      nxt = '0;
      case (d.opcode)
        OP_SETTING:   apply_setting(d.setting_automatic, d.interval_value, now);
        OP_SCAN_DONE: scan_later();
        OP_NOT_CONN:  scan_now();
        OP_TIMER:     if (mode == MODE_CODE_AUTO) apply_setting(1'b1, '0, now);
        OP_AGENT_IVL: agent_update(d.interval_value);
        default: ;
      endcase
      nxt.interval_now = ival;
      nxt.scan_enabled = (ival != 0);
      nxt.mode_now     = mode;
      pending_decisions.push_back(nxt);
    endfunction

    function void compare(string f, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        errors++;
        $display("%0t: %s expected %0d actual %0d", $time, f, e, a);
      end
    endfunction

    function void check_decision(out_t got);
      out_t want;
      if (pending_decisions.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing pending, expected none actual %h",
                 $time, got);
        return;
      end
      want = pending_decisions.pop_front();
      compare("cancel_scan", want.cancel_scan, got.cancel_scan);
      compare("scan_request", want.scan_request, got.scan_request);
      compare("scan_expiry", want.scan_expiry, got.scan_expiry);
      compare("agent_command", want.agent_command, got.agent_command);
      compare("timer_action", want.timer_action, got.timer_action);
      compare("change_at_minute", want.change_at_minute, got.change_at_minute);
      compare("change_next_day", want.change_next_day, got.change_next_day);
      compare("interval_now", want.interval_now, got.interval_now);
      compare("scan_enabled", want.scan_enabled, got.scan_enabled);
      compare("mode_now", want.mode_now, got.mode_now);
    endfunction

    function int pending();
      return pending_decisions.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [11:0] cfg_data = '0;

  decision_board board;
  int send_pct = 0;
  int recv_pct = 0;
  int hold_ask = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycles = 0;

  wlan_background_scan_policy dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** wlan_background_scan_policy: FAILED **");
      $finish;
    end
  end

  // result side: check accepted beats, random stall, long hold on request
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) board.check_decision(out_data);
    if (hold_seen != hold_ask) begin
      hold_seen = hold_ask;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else out_stall <= ($urandom_range(99) < recv_pct);
  end

  task automatic send_event(input in_t d);
    if (send_pct > 0 && $urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_pct);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.predict_event(d);
  endtask

  task automatic ev(input logic [2:0] op, input bit a, input logic [15:0] v,
                    input logic [16:0] now);
    in_t d;
    d.opcode            = op;
    d.setting_automatic = a;
    d.interval_value    = v;
    d.now_seconds       = now;
    send_event(d);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [11:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_policy(input int s, input int e, input int pi, input int oi,
                            input int ag);
    cfg_write(CFG_PEAK_START, 12'(s));
    cfg_write(CFG_PEAK_END, 12'(e));
    cfg_write(CFG_PEAK_INTERVAL, 12'(pi));
    cfg_write(CFG_OFFPEAK_IVAL, 12'(oi));
    cfg_write(CFG_AGENT_PRESENT, 12'(ag));
  endtask

  function automatic int pick_hhmm();
    return ($urandom_range(99) < 80) ? $urandom_range(2359) : $urandom_range(4095);
  endfunction

  function automatic int pick_ival();
    return ($urandom_range(99) < 80) ? $urandom_range(1800) : $urandom_range(4095);
  endfunction

  function automatic in_t random_event();
    in_t d;
    int  k;
    int  now;
    k = $urandom_range(99);
    if (k < 30) d.opcode = OP_SETTING;
    else if (k < 45) d.opcode = OP_SCAN_DONE;
    else if (k < 55) d.opcode = OP_NOT_CONN;
    else if (k < 78) d.opcode = OP_TIMER;
    else if (k < 95) d.opcode = OP_AGENT_IVL;
    else d.opcode = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
    d.setting_automatic = ($urandom_range(99) < 45);
    k = $urandom_range(99);
    if (k < 15) d.interval_value = '0;
    else if (k < 30) d.interval_value = board.ival;
    else if (k < 70) d.interval_value = 16'($urandom_range(1800, 1));
    else d.interval_value = 16'($urandom_range(65535));
    k = $urandom_range(99);
    if (k < 20) begin
      now = $urandom_range(1) ? board.start_sec() : board.end_sec();
      now = now + $urandom_range(2) - 1;
    end else if (k < 28) now = $urandom_range(131071);
    else now = $urandom_range(86399);
    d.now_seconds = 17'(now);
    return d;
  endfunction

  initial begin
    board = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_policy(930, 1775, 300, 1200, 0);
    ev(OP_SCAN_DONE, 1'b0, '0, '0);
    ev(OP_NOT_CONN, 1'b1, 16'hFFFF, 17'h1FFFF);
    ev(OP_TIMER, 1'b1, '0, 17'd40000);
    ev(OP_AGENT_IVL, 1'b0, 16'd100, '0);
    ev(OP_UNUSED_LO, 1'b1, 16'hFFFF, 17'h1FFFF);
    ev(OP_UNUSED_HI, 1'b0, '0, '0);
    ev(OP_SETTING, 1'b0, 16'hFFFF, '0);
    ev(OP_SETTING, 1'b0, 16'hFFFF, '0);
    ev(OP_SETTING, 1'b0, 16'd1, '0);
    ev(OP_SETTING, 1'b0, 16'd300, '0);
    ev(OP_SCAN_DONE, 1'b0, '0, '0);
    ev(OP_SETTING, 1'b1, '0, '0);
    ev(OP_TIMER, 1'b0, '0, 17'd34200);
    ev(OP_TIMER, 1'b0, '0, 17'd64740);
    ev(OP_TIMER, 1'b0, '0, 17'h1FFFF);
    ev(OP_SETTING, 1'b1, '0, 17'd50000);
    ev(OP_SETTING, 1'b0, 16'd500, '0);
    ev(OP_SETTING, 1'b0, '0, '0);
    ev(OP_SETTING, 1'b1, '0, 17'd86399);
    ev(OP_SETTING, 1'b0, '0, '0);
    settle();

    set_policy(2200, 630, 60, 0, 1);
    ev(OP_SETTING, 1'b1, '0, '0);
    ev(OP_AGENT_IVL, 1'b0, '0, '0);
    ev(OP_AGENT_IVL, 1'b0, 16'd600, '0);
    ev(OP_AGENT_IVL, 1'b0, 16'd100, '0);
    ev(OP_AGENT_IVL, 1'b0, 16'hFFFF, '0);
    ev(OP_TIMER, 1'b1, '0, '0);
    ev(OP_SETTING, 1'b1, '0, '0);
    ev(OP_SETTING, 1'b0, 16'd777, '0);
    ev(OP_SETTING, 1'b1, '0, '0);
    ev(OP_SETTING, 1'b0, '0, '0);
    settle();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: set_policy(0, 0, 0, 0, 0);
        1: set_policy(2359, 0, 1800, 1801, 0);
        2: set_policy(4095, 4095, 4095, 4095, 1);
        3: set_policy(2400, 1000, 0, 1800, 0);
        4: set_policy(1234, 1234, 300, 600, 0);
        5: set_policy(2300, 600, 120, 30, 1);
        6: set_policy(975, 1799, 1, 1, 0);
        default: set_policy(pick_hhmm(), pick_hhmm(), pick_ival(), pick_ival(),
                            $urandom_range(1));
      endcase
      if (ph % 2 == 1) cfg_write(CFG_UNUSED_LO + 3'(ph % 3), 12'($urandom_range(4095)));
      case (ph % 4)
        0: begin send_pct = 0;  recv_pct = 0;  end
        1: begin send_pct = 48; recv_pct = 0;  end
        2: begin send_pct = 0;  recv_pct = 48; end
        default: begin send_pct = 17; recv_pct = 17; end
      endcase
      if (ph == 4) hold_ask++;
      repeat (PHASE_EVENTS) send_event(random_event());
      settle();
    end

    if (board.errors == 0 && board.pending() == 0)
      $display("** wlan_background_scan_policy: PASSED **");
    else
      $display("** wlan_background_scan_policy: FAILED **");
    $finish;
  end

endmodule

[wlan_background_scan_policy.f]
rtl/core/wbsp_pkg.sv
rtl/core/wbsp_window.sv
rtl/core/wbsp_decide.sv
rtl/core/wlan_background_scan_policy.sv
tb/sv/tb.sv
